// File: sv/keyed_value_table_defines.svh
// Assertion macros for the keyed value table checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef KEYED_VALUE_TABLE_DEFINES_SVH
`define KEYED_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KVT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_value_table: property failed");

// Next-cycle implication, disabled during reset.
`define KVT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_value_table: property failed");

`endif

// File: sv/kvt_pkg.sv
// Shared types, widths and the unit string cleanup for the keyed value table.
// No dependencies.
package kvt_pkg;

  localparam int KEY_W      = 32;
  localparam int VALUE_W    = 64;
  localparam int UNIT_W     = 56;
  localparam int UNIT_CHARS = 7;
  localparam int UNIT_LIMIT = (UNIT_CHARS < 7) ? UNIT_CHARS : 7;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value_in;
    logic [UNIT_W-1:0]  unit_in;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value_out;
    logic [UNIT_W-1:0]  unit_out;
  } rsp_t;

  // Keep bytes up to the first zero byte, at most UNIT_LIMIT of them.
  function automatic logic [UNIT_W-1:0] unit_clean(input logic [UNIT_W-1:0] raw);
    logic [UNIT_W-1:0] res;
    logic              stop;
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < UNIT_LIMIT; b++) begin
      if (raw[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage

// File: sv/keyed_value_table.sv
// Keyed value table: up to CAPACITY entries of key, 64-bit value and unit string.
// Depends on kvt_pkg. Key and data arrays are synchronous memories inside this module.
//
// One request at a time. A request with a nonzero key scans the stored keys in
// insertion order, one key memory read per cycle, stopping at the first match.
// A set then writes the data memory (and the key memory on append); a get hit
// then reads the data memory. The scan goes through the single read port of the
// key memory. A key of zero skips the scan. The next request is taken once the
// block is back in idle, even while the last response is still waiting on
// rsp_ready.
module keyed_value_table #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  kvt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kvt_pkg::rsp_t rsp
);
  import kvt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = VALUE_W + UNIT_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_ACT    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]         state;
  logic               op;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic [UNIT_W-1:0]  unit;
  logic [CW-1:0]      used;
  logic [CW-1:0]      cnt;
  logic               pend;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      hit_idx;
  logic               found;
  rsp_t               res;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [DW-1:0]    data_mem [CAPACITY];
  logic [KEY_W-1:0] key_rd;
  logic [DW-1:0]    data_rd;

  logic          key_rd_en;
  logic          match;
  logic          table_full;
  logic          key_we;
  logic          data_we;
  logic [AW-1:0] data_wr_addr;
  logic          data_rd_en;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    key_rd_en    = (state == ST_SCAN) && (cnt < used);
    match        = (state == ST_SCAN) && pend && (key_rd == key);
    table_full   = (used == CW'(CAPACITY));
    key_we       = (state == ST_ACT) && (op == OP_SET) && !found && !table_full;
    data_we      = (state == ST_ACT) && (op == OP_SET) && (found || !table_full);
    data_wr_addr = found ? hit_idx : used[AW-1:0];
    data_rd_en   = (state == ST_ACT) && (op == OP_GET) && found;
  end

  always_ff @(posedge clk) begin
    if (key_rd_en) begin
      key_rd <= key_mem[cnt[AW-1:0]];
    end
    if (key_we) begin
      key_mem[used[AW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (data_rd_en) begin
      data_rd <= data_mem[hit_idx];
    end
    if (data_we) begin
      data_mem[data_wr_addr] <= {value, unit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != ST_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            op    <= req.operation;
            key   <= req.key;
            value <= req.value_in;
            unit  <= unit_clean(req.unit_in);
            cnt   <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            res   <= '0;
            state <= (req.key == '0) ? ST_RESULT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend <= key_rd_en && !match;
          if (key_rd_en) begin
            cnt    <= cnt + 1'b1;
            rd_idx <= cnt[AW-1:0];
          end
          if (match) begin
            found   <= 1'b1;
            hit_idx <= rd_idx;
            state   <= ST_ACT;
          end else if (!key_rd_en) begin
            state <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (op == OP_GET) begin
            state <= found ? ST_READ : ST_RESULT;
          end else begin
            res.ok <= found || !table_full;
            if (!found && !table_full) begin
              used <= used + 1'b1;
            end
            state <= ST_RESULT;
          end
        end
        ST_READ: begin
          res.ok        <= 1'b1;
          res.value_out <= data_rd[DW-1:UNIT_W];
          res.unit_out  <= data_rd[UNIT_W-1:0];
          state         <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/kvt_checker.sv
// Port-level checks for the keyed value table, bound to every instance.
// Depends on kvt_pkg and keyed_value_table_defines.svh.
`include "keyed_value_table_defines.svh"

module kvt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input kvt_pkg::rsp_t rsp
);
  import kvt_pkg::*;

  logic [1:0] owed;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else if (req_fire && !rsp_fire) begin
      owed <= owed + 1'b1;
    end else if (rsp_fire && !req_fire) begin
      owed <= owed - 1'b1;
    end
  end

  `KVT_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `KVT_ASSERT_IMP(a_rsp_owed, clk, rst, rsp_valid, owed != 2'd0)
  `KVT_ASSERT_IMP(a_owed_bound, clk, rst, 1'b1, owed != 2'd3)
  `KVT_ASSERT_NXT(a_busy_after_req, clk, rst, req_fire, !req_ready)
  `KVT_ASSERT_IMP(a_fail_zero, clk, rst, rsp_valid && !rsp.ok,
                  rsp.value_out == '0 && rsp.unit_out == '0)

endmodule

bind keyed_value_table kvt_checker u_kvt_checker (.*);

// File: dv/tb_keyed_value_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_value_table: directed and random set/get requests
// checked against a behavioral table kept in the bench. Depends on kvt_pkg and the RTL.
module tb_keyed_value_table;
  import kvt_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  localparam int UNIT_BYTES    = (UNIT_CHARS < 7) ? UNIT_CHARS : 7;
  localparam int KEY_POOL_SIZE = 96;
  localparam int RANDOM_ITEMS  = 1480;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = TABLE_DEPTH + 16;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  logic [KEY_W-1:0]   stored_keys   [TABLE_DEPTH];
  logic [VALUE_W-1:0] stored_values [TABLE_DEPTH];
  logic [UNIT_W-1:0]  stored_units  [TABLE_DEPTH];
  int                 fill_count = 0;
  logic [KEY_W-1:0]   key_pool      [KEY_POOL_SIZE];

  rsp_t pending_answers [$];
  int   mismatch_count = 0;
  int   answers_checked = 0;
  int   n_requests = 0;
  int   n_appends = 0;
  int   n_overwrites = 0;
  int   n_full = 0;
  int   n_zero_key = 0;
  int   n_hits = 0;
  int   n_misses = 0;

  keyed_value_table #(
    .CAPACITY(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [UNIT_W-1:0] trim_unit(input logic [UNIT_W-1:0] raw);
    logic [UNIT_W-1:0] res;
    res = '0;
    for (int b = 0; b < UNIT_BYTES && raw[8*b +: 8] != 8'h00; b++) begin
      res[8*b +: 8] = raw[8*b +: 8];
    end
    return res;
  endfunction

  function automatic rsp_t table_access(input req_t r);
    rsp_t ans;
    int   slot;
    ans  = '0;
    slot = -1;
    n_requests++;
    for (int i = 0; i < fill_count; i++) begin
      if (slot < 0 && stored_keys[i] == r.key) begin
        slot = i;
      end
    end
    if (r.key == '0) begin
      n_zero_key++;
    end else if (r.operation == OP_SET) begin
      if (slot >= 0) begin
        stored_values[slot] = r.value_in;
        stored_units[slot]  = trim_unit(r.unit_in);
        ans.ok = 1'b1;
        n_overwrites++;
      end else if (fill_count < TABLE_DEPTH) begin
        stored_keys[fill_count]   = r.key;
        stored_values[fill_count] = r.value_in;
        stored_units[fill_count]  = trim_unit(r.unit_in);
        fill_count++;
        ans.ok = 1'b1;
        n_appends++;
      end else begin
        n_full++;
      end
    end else if (slot >= 0) begin
      ans.ok        = 1'b1;
      ans.value_out = stored_values[slot];
      ans.unit_out  = trim_unit(stored_units[slot]);
      n_hits++;
    end else begin
      n_misses++;
    end
    return ans;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [UNIT_W-1:0] random_unit();
    logic [UNIT_W-1:0] u;
    u = '0;
    for (int b = 0; b < UNIT_W / 8; b++) begin
      case ($urandom_range(0, 7))
        0: u[8*b +: 8] = 8'h00;
        1: u[8*b +: 8] = 8'($urandom_range(0, 255));
        default: u[8*b +: 8] = 8'($urandom_range(33, 126));
      endcase
    end
    return u;
  endfunction

  function automatic logic [KEY_W-1:0] unused_key();
    logic [KEY_W-1:0] k;
    bit               taken;
    do begin
      k     = $urandom;
      taken = (k == '0);
      for (int i = 0; i < fill_count; i++) begin
        if (stored_keys[i] == k) begin
          taken = 1'b1;
        end
      end
    end while (taken);
    return k;
  endfunction

  task automatic report_mismatch(input string field, input int index,
                                 input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 200) begin
      $display("[%0t] response %0d, %s: got %h, expected %h", $realtime, index, field,
               got, want);
    end
  endtask

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value,
                              input logic [UNIT_W-1:0] unit);
    req_t item;
    item.operation = op;
    item.key       = key;
    item.value_in  = value;
    item.unit_in   = unit;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    pending_answers.push_back(table_access(item));
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic test_empty_and_zero_key();
    send_request(OP_GET, 32'h0000_0001, '0, '0);
    idle_sender($urandom_range(0, 3));
    send_request(OP_SET, '0, '1, '1);
    idle_sender($urandom_range(0, 3));
    send_request(OP_GET, '0, '1, '1);
    send_request(OP_GET, 32'hFFFF_FFFF, '0, '0);
  endtask

  task automatic test_extremes_and_units();
    send_request(OP_SET, 32'hFFFF_FFFF, '1, '1);
    send_request(OP_GET, 32'hFFFF_FFFF, '0, '0);
    idle_sender($urandom_range(0, 3));
    send_request(OP_SET, 32'h0000_0001, '0, '0);
    send_request(OP_GET, 32'h0000_0001, '1, '1);
    idle_sender($urandom_range(0, 3));
    // zero byte in the middle: only the bytes below it survive
    send_request(OP_SET, 32'h8000_0000, 64'h8000_0000_0000_0001, 56'hFF_FFFF_FF00_4D6B);
    send_request(OP_GET, 32'h8000_0000, '0, '0);
    send_request(OP_SET, 32'h7FFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE, 56'h00_7A79_7877_7675);
    send_request(OP_GET, 32'h7FFF_FFFE, '0, '0);
  endtask

  task automatic test_overwrite();
    send_request(OP_SET, 32'h0000_0001, 64'h0123_4567_89AB_CDEF, 56'h73);
    send_request(OP_GET, 32'h0000_0001, '0, '0);
    idle_sender($urandom_range(0, 3));
    send_request(OP_SET, '0, 64'hDEAD_BEEF_0000_0000, 56'h6D);
    send_request(OP_GET, 32'h0000_0001, '0, '0);
    send_request(OP_GET, 32'hFFFF_FFFF, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int               burst_left;
    int               pick;
    logic             op;
    logic [KEY_W-1:0] key;
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h8000_0000;
    for (int i = 3; i < KEY_POOL_SIZE; i++) begin
      do key_pool[i] = $urandom; while (key_pool[i] == '0);
    end
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        wait_drained();
      end else if (burst_left == 0) begin
        idle_sender($urandom_range(1, 20));
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        key = '0;
      end else if (pick < 10) begin
        key = $urandom;
      end else begin
        key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      end
      op = ($urandom_range(0, 99) < 45) ? OP_SET : OP_GET;
      send_request(op, key, random_value(), random_unit());
      if (burst_left > 0) begin
        burst_left--;
      end
    end
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] spare;
    // top up so the next new key has nowhere to go
    while (fill_count < TABLE_DEPTH) begin
      send_request(OP_SET, unused_key(), random_value(), random_unit());
    end
    spare = unused_key();
    send_request(OP_SET, spare, random_value(), random_unit());
    send_request(OP_GET, spare, '0, '0);
    send_request(OP_SET, stored_keys[TABLE_DEPTH-1], random_value(), random_unit());
    send_request(OP_GET, stored_keys[TABLE_DEPTH-1], '0, '0);
    send_request(OP_GET, stored_keys[0], '0, '0);
    wait_drained();
  endtask

  initial begin : receiver_stalls
    int cycle;
    int stall_left;
    cycle      = 0;
    stall_left = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      case ((cycle / 256) % 4)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        2: rsp_ready <= (cycle % 5 == 0);
        default: begin
          if (stall_left == 0) begin
            rsp_ready  <= 1'b1;
            stall_left = $urandom_range(0, 40);
          end else begin
            rsp_ready <= 1'b0;
            stall_left--;
          end
        end
      endcase
    end
  end

  initial begin : answer_check
    rsp_t got;
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected response", answers_checked, rsp.value_out, '0);
        end else begin
          got  = rsp;
          want = pending_answers.pop_front();
          if (got.ok !== want.ok) begin
            report_mismatch("ok", answers_checked, VALUE_W'(got.ok), VALUE_W'(want.ok));
          end
          if (got.value_out !== want.value_out) begin
            report_mismatch("value_out", answers_checked, got.value_out, want.value_out);
          end
          if (got.unit_out !== want.unit_out) begin
            report_mismatch("unit_out", answers_checked, VALUE_W'(got.unit_out),
                            VALUE_W'(want.unit_out));
          end
        end
        answers_checked++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: %0d cycles without a request or response", quiet);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_zero_key();
    test_extremes_and_units();
    test_overwrite();
    test_random_traffic(RANDOM_ITEMS);
    test_table_full();

    req_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d appends, %0d overwrites,", n_requests, n_appends,
             n_overwrites);
    $display("%0d table-full rejects, %0d zero keys; lookups: %0d hits, %0d misses",
             n_full, n_zero_key, n_hits, n_misses);
    $display("%0d responses checked", answers_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/kvt_pkg.sv
sv/keyed_value_table.sv
sv/kvt_checker.sv
dv/tb_keyed_value_table.sv
